[rtl/led_pkg.sv]
// Shared types and constants of the line editor with echo.
`default_nettype none
package led_pkg;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_NUL   = 8'd0;

    localparam logic [4:0] MAX_LENGTH_RESET = 5'd19;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } res_word_t;

endpackage
`default_nettype wire

[rtl/led_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module led_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

[rtl/led_ctrl.sv]
// Line editor sequencer: classifies bytes, keeps the line length, walks the line store.
`default_nettype none
module led_ctrl #(
    parameter int LINE_BYTES = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [4:0]                    cfg_data,
    input  wire logic                          slot_free,
    output logic                               res_load,
    output led_pkg::res_word_t                 res_word,
    output logic                               ram_we,
    output logic [$clog2(LINE_BYTES)-1:0]      ram_waddr,
    output logic [7:0]                         ram_wdata,
    output logic [$clog2(LINE_BYTES)-1:0]      ram_raddr,
    input  wire logic [7:0]                    ram_rdata
);

    localparam int AW   = $clog2(LINE_BYTES);
    localparam int LW   = $clog2(LINE_BYTES + 1);
    localparam int CMPW = (LW > 5) ? LW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ECHO = 2'd1;
    localparam logic [1:0] S_LINE = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    localparam logic [1:0] CASE_STORE = 2'd0;
    localparam logic [1:0] CASE_FULL  = 2'd1;
    localparam logic [1:0] CASE_BS    = 2'd2;
    localparam logic [1:0] CASE_CR    = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [4:0]    max_len_reg, max_len_next;
    logic [7:0]    rx_reg, rx_next;
    logic [1:0]    case_reg, case_next;
    logic [1:0]    step_reg, step_next;
    logic [2:0]    n_echo_reg, n_echo_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          ok_reg, ok_next;

    logic          accept;
    logic          full;
    logic          step_last;
    logic          idx_last;
    logic [7:0]    echo_byte;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign full = (CMPW'(len_reg) >= CMPW'(max_len_reg)) ||
                  (CMPW'(len_reg) >= CMPW'(LINE_BYTES));

    assign step_last = (({1'b0, step_reg} + 3'd1) == n_echo_reg);
    assign idx_last  = ((LW'(idx_reg) + LW'(1)) == len_reg);

    assign ram_waddr = len_reg[AW-1:0];
    assign ram_wdata = s_tdata;
    assign ram_raddr = idx_reg;

    always_comb begin
        echo_byte = rx_reg;
        unique case (case_reg)
            CASE_CR: begin
                case (step_reg)
                    2'd1:    echo_byte = led_pkg::BYTE_CR;
                    2'd2:    echo_byte = led_pkg::BYTE_LF;
                    default: echo_byte = rx_reg;
                endcase
            end
            CASE_BS: begin
                case (step_reg)
                    2'd1:    echo_byte = led_pkg::BYTE_SPACE;
                    2'd2:    echo_byte = led_pkg::BYTE_BS;
                    default: echo_byte = rx_reg;
                endcase
            end
            CASE_FULL: begin
                case (step_reg)
                    2'd1:    echo_byte = led_pkg::BYTE_BS;
                    2'd2:    echo_byte = led_pkg::BYTE_SPACE;
                    2'd3:    echo_byte = led_pkg::BYTE_BS;
                    default: echo_byte = rx_reg;
                endcase
            end
            default: echo_byte = rx_reg;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        max_len_next = max_len_reg;
        rx_next      = rx_reg;
        case_next    = case_reg;
        step_next    = step_reg;
        n_echo_next  = n_echo_reg;
        idx_next     = idx_reg;
        ok_next      = ok_reg;
        res_load     = 1'b0;
        res_word     = '{kind: led_pkg::KIND_ECHO, data: echo_byte, last: 1'b0};
        ram_we       = 1'b0;

        if (cfg_valid && cfg_ready) begin
            max_len_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    rx_next    = s_tdata;
                    step_next  = 2'd0;
                    state_next = S_ECHO;
                    if (s_tdata == led_pkg::BYTE_CR) begin
                        case_next   = CASE_CR;
                        n_echo_next = 3'd3;
                    end else if (s_tdata == led_pkg::BYTE_BS) begin
                        case_next = CASE_BS;
                        if (len_reg != '0) begin
                            n_echo_next = 3'd3;
                            len_next    = len_reg - LW'(1);
                        end else begin
                            n_echo_next = 3'd2;
                        end
                    end else if (full) begin
                        case_next   = CASE_FULL;
                        n_echo_next = 3'd4;
                    end else begin
                        case_next   = CASE_STORE;
                        n_echo_next = 3'd1;
                        ram_we      = 1'b1;
                        len_next    = len_reg + LW'(1);
                    end
                end
            end
            S_ECHO: begin
                if (slot_free) begin
                    res_load      = 1'b1;
                    res_word.last = step_last && (case_reg != CASE_CR);
                    if (step_last) begin
                        if (case_reg == CASE_CR) begin
                            idx_next   = '0;
                            ok_next    = 1'b0;
                            state_next = (len_reg == '0) ? S_END : S_LINE;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            S_LINE: begin
                ok_next = 1'b1;
                if (ok_reg && slot_free) begin
                    res_load = 1'b1;
                    res_word = '{kind: led_pkg::KIND_LINE, data: ram_rdata, last: 1'b0};
                    ok_next  = 1'b0;
                    if (idx_last) begin
                        state_next = S_END;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            S_END: begin
                if (slot_free) begin
                    res_load   = 1'b1;
                    res_word   = '{kind: led_pkg::KIND_END, data: led_pkg::BYTE_NUL,
                                   last: 1'b1};
                    len_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            max_len_reg <= led_pkg::MAX_LENGTH_RESET;
            ok_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            max_len_reg <= max_len_next;
            ok_reg      <= ok_next;
        end
        rx_reg     <= rx_next;
        case_reg   <= case_next;
        step_reg   <= step_next;
        n_echo_reg <= n_echo_next;
        idx_reg    <= idx_next;
    end

endmodule
`default_nettype wire

[rtl/led_obuf.sv]
// Output register holding one result word for the master-side stream.
`default_nettype none
module led_obuf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               res_load,
    input  wire led_pkg::res_word_t res_word,
    output logic                    slot_free,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);

    logic               valid_reg, valid_next;
    led_pkg::res_word_t word_reg, word_next;

    assign slot_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (res_load) begin
            valid_next = 1'b1;
            word_next  = res_word;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        word_reg <= word_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg.data;
    assign m_tuser  = word_reg.kind;
    assign m_tlast  = word_reg.last;

endmodule
`default_nettype wire

[rtl/line_editor_with_echo_top.sv]
// Line editor with echo: takes one terminal byte per word and gives echo and line words.
// The first result word goes from the sequencer's echo state into the output register.
// A new input byte is accepted only after every result word of the last byte, and for a
// carriage return each line byte after its registered RAM read, has been loaded.
// Reset clears the sequencer, the output register and the line length, and sets the
// maximum length to 19; the line store RAM keeps its contents and needs no clearing pass.
`default_nettype none
module line_editor_with_echo_top #(
    parameter int LINE_BYTES = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser,   // [1:0] kind
    output logic            m_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_data
);

    localparam int AW = $clog2(LINE_BYTES);

    logic               slot_free;
    logic               res_load;
    led_pkg::res_word_t res_word;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    led_ctrl #(
        .LINE_BYTES (LINE_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res_word  (res_word),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    led_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    led_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_load  (res_load),
        .res_word  (res_word),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire
